### hw/rtl/mfir_pkg.sv
// shared types and constants for the multichannel fir ring filter
`default_nettype none

package mfir_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int RESULT_W     = 32;
    localparam int TAP_IDX_W    = 5;
    localparam int FRAC_W       = 15;
    localparam int NUM_OUT      = 6;
    localparam int WINDOW_DEF   = 32;
    localparam int CHANNELS_DEF = 6;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [RESULT_W-1:0] result_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } mfir_mac_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/mfir_sample_if.sv
// input channel: tap loads and sample sets
`default_nettype none

interface mfir_sample_if;
    import mfir_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic        [TAP_IDX_W-1:0]   tap_index;
    logic signed [SAMPLE_W-1:0]    coef_value;
    logic signed [SAMPLE_W-1:0]    sample_ch0;
    logic signed [SAMPLE_W-1:0]    sample_ch1;
    logic signed [SAMPLE_W-1:0]    sample_ch2;
    logic signed [SAMPLE_W-1:0]    sample_ch3;
    logic signed [SAMPLE_W-1:0]    sample_ch4;
    logic signed [SAMPLE_W-1:0]    sample_ch5;

    modport source (
        output valid, opcode, tap_index, coef_value,
        output sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4, sample_ch5,
        input  ready
    );

    modport sink (
        input  valid, opcode, tap_index, coef_value,
        input  sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4, sample_ch5,
        output ready
    );

endinterface

`default_nettype wire

### hw/rtl/mfir_result_if.sv
// output channel: filtered channel set
`default_nettype none

interface mfir_result_if;
    import mfir_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [RESULT_W-1:0]  filtered_ch0;
    logic signed [RESULT_W-1:0]  filtered_ch1;
    logic signed [RESULT_W-1:0]  filtered_ch2;
    logic signed [RESULT_W-1:0]  filtered_ch3;
    logic signed [RESULT_W-1:0]  filtered_ch4;
    logic signed [RESULT_W-1:0]  filtered_ch5;

    modport source (
        output valid,
        output filtered_ch0, filtered_ch1, filtered_ch2,
        output filtered_ch3, filtered_ch4, filtered_ch5,
        input  ready
    );

    modport sink (
        input  valid,
        input  filtered_ch0, filtered_ch1, filtered_ch2,
        input  filtered_ch3, filtered_ch4, filtered_ch5,
        output ready
    );

endinterface

`default_nettype wire

### hw/rtl/mfir_ram.sv
// simple dual-port ram with registered read
`default_nettype none

module mfir_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mfir_mac.sv
// one multiply-accumulate lane with q15 shift and saturation
`default_nettype none

module mfir_mac #(
    parameter int WINDOW = mfir_pkg::WINDOW_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mfir_pkg::mfir_mac_ctl_t        ctl,
    input  wire logic signed [mfir_pkg::SAMPLE_W-1:0] sample,
    input  wire logic signed [mfir_pkg::SAMPLE_W-1:0] coef,
    output      logic signed [mfir_pkg::RESULT_W-1:0] result
);
    import mfir_pkg::*;

    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int ACC_W  = PROD_W + $clog2(WINDOW);
    localparam int EXT_W  = (ACC_W > RESULT_W) ? ACC_W : RESULT_W + 1;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  shifted;
    logic signed [EXT_W-1:0]  shifted_ext;
    logic [EXT_W-RESULT_W:0]  top_bits;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= sample * coef;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.acc_en)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // floor shift, then clamp to the signed result range
    always_comb
    begin
        shifted     = acc_reg >>> FRAC_W;
        shifted_ext = EXT_W'(shifted);
        top_bits    = shifted_ext[EXT_W-1:RESULT_W-1];
        if ((&top_bits) || !(|top_bits))
        begin
            result = shifted_ext[RESULT_W-1:0];
        end
        else if (shifted_ext[EXT_W-1])
        begin
            result = {1'b1, {(RESULT_W-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(RESULT_W-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

### hw/rtl/multichannel_fir_ring_filter.sv
// top level: multichannel fir filter over per-channel sample rings
//
// sample_chan carries one transaction per item. opcode load writes one
// q1.15 tap (ignored when tap_index is beyond the window) and gives no
// result. opcode sample stores one sample per channel at the ring write
// pointer and yields one transaction on result_chan holding, per channel,
// the tap-weighted sum of the last WINDOW samples, shifted right 15 and
// saturated. with enable_reg low a sample transaction leaves the rings
// alone and yields all zeros.
// an enabled sample walks the taps: the history row and tap are read
// once per cycle, one tap per cycle, feeding one multiply-accumulate
// lane per channel. a disabled sample goes straight to the done state.
// sample_chan.ready is high only while the sequencer is idle.
// the result sits in an output register; a stalled receiver holds the
// next result in the sequencer until the register frees up.
// reset clears taps, rings (through a fill flag), pointer and enable.
`default_nettype none

module multichannel_fir_ring_filter #(
    parameter int WINDOW   = mfir_pkg::WINDOW_DEF,
    parameter int CHANNELS = mfir_pkg::CHANNELS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata,
    mfir_sample_if.sink   sample_chan,
    mfir_result_if.source result_chan
);
    import mfir_pkg::*;

    localparam int PW    = $clog2(WINDOW);
    localparam int ROW_W = CHANNELS * SAMPLE_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic              enable_reg;
    logic [PW-1:0]     wp_reg, wp_next;
    logic              full_reg, full_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]     tap_cnt_reg, tap_cnt_next;
    logic              s1_reg, s1_next;
    logic              s2_reg;
    logic              hist_ok_reg, tap_ok_reg;
    logic [WINDOW-1:0] tap_valid_reg;
    logic              out_valid_reg;
    result_t           out_reg [NUM_OUT];

    logic              in_acc;
    logic              is_load, is_sample;
    logic              tap_we;
    logic              hist_we;
    logic              issue;
    logic              out_load;
    logic [ROW_W-1:0]  hist_wdata;
    logic [ROW_W-1:0]  hist_rdata;
    logic [SAMPLE_W-1:0] tap_rdata;
    sample_t           coef_m;
    sample_t           in_samp [NUM_OUT];
    result_t           lane_res [NUM_OUT];
    mfir_mac_ctl_t     mac_ctl;

    assign in_acc    = sample_chan.valid && sample_chan.ready;
    assign is_load   = in_acc && (sample_chan.opcode == OP_LOAD);
    assign is_sample = in_acc && (sample_chan.opcode == OP_SAMPLE);
    assign tap_we    = is_load && (int'(sample_chan.tap_index) < WINDOW);
    assign hist_we   = is_sample && enable_reg;
    assign issue     = (state_reg == ST_RUN);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || result_chan.ready);

    assign sample_chan.ready = (state_reg == ST_IDLE);

    assign in_samp[0] = sample_chan.sample_ch0;
    assign in_samp[1] = sample_chan.sample_ch1;
    assign in_samp[2] = sample_chan.sample_ch2;
    assign in_samp[3] = sample_chan.sample_ch3;
    assign in_samp[4] = sample_chan.sample_ch4;
    assign in_samp[5] = sample_chan.sample_ch5;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            hist_wdata[c*SAMPLE_W +: SAMPLE_W] = in_samp[c];
        end
    end

    mfir_ram #(
        .DEPTH (WINDOW),
        .WIDTH (ROW_W)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (wp_reg),
        .wdata (hist_wdata),
        .re    (issue),
        .raddr (rd_ptr_reg),
        .rdata (hist_rdata)
    );

    mfir_ram #(
        .DEPTH (WINDOW),
        .WIDTH (SAMPLE_W)
    ) u_tap_ram (
        .clk   (clk),
        .we    (tap_we),
        .waddr (PW'(sample_chan.tap_index)),
        .wdata (sample_chan.coef_value),
        .re    (issue),
        .raddr (tap_cnt_reg),
        .rdata (tap_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        full_next    = full_reg;
        rd_ptr_next  = rd_ptr_reg;
        tap_cnt_next = tap_cnt_reg;
        s1_next      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_sample)
                begin
                    if (enable_reg)
                    begin
                        rd_ptr_next  = wp_reg;
                        tap_cnt_next = '0;
                        if (wp_reg == PW'(WINDOW - 1))
                        begin
                            wp_next   = '0;
                            full_next = 1'b1;
                        end
                        else
                        begin
                            wp_next = wp_reg + 1'b1;
                        end
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RUN:
            begin
                s1_next      = 1'b1;
                tap_cnt_next = tap_cnt_reg + 1'b1;
                rd_ptr_next  = (rd_ptr_reg == '0) ? PW'(WINDOW - 1) : rd_ptr_reg - 1'b1;
                if (tap_cnt_reg == PW'(WINDOW - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_reg && !s2_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enable_reg    <= 1'b0;
            wp_reg        <= '0;
            full_reg      <= 1'b0;
            rd_ptr_reg    <= '0;
            tap_cnt_reg   <= '0;
            s1_reg        <= 1'b0;
            s2_reg        <= 1'b0;
            hist_ok_reg   <= 1'b0;
            tap_ok_reg    <= 1'b0;
            tap_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            full_reg    <= full_next;
            rd_ptr_reg  <= rd_ptr_next;
            tap_cnt_reg <= tap_cnt_next;
            s1_reg      <= s1_next;
            s2_reg      <= s1_reg;
            // unwritten ring entries and taps read as zero
            hist_ok_reg <= full_reg || (rd_ptr_reg < wp_reg);
            tap_ok_reg  <= tap_valid_reg[tap_cnt_reg];
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
            if (tap_we)
            begin
                tap_valid_reg[PW'(sample_chan.tap_index)] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign mac_ctl.clear  = is_sample;
    assign mac_ctl.mul_en = s1_reg;
    assign mac_ctl.acc_en = s2_reg;
    assign coef_m         = tap_ok_reg ? tap_rdata : '0;

    for (genvar c = 0; c < NUM_OUT; c++)
    begin : g_lane
        if (c < CHANNELS)
        begin : g_mac
            sample_t samp_m;

            assign samp_m = hist_ok_reg ? hist_rdata[c*SAMPLE_W +: SAMPLE_W] : '0;

            mfir_mac #(
                .WINDOW (WINDOW)
            ) u_mac (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (mac_ctl),
                .sample (samp_m),
                .coef   (coef_m),
                .result (lane_res[c])
            );
        end
        else
        begin : g_zero
            assign lane_res[c] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int c = 0; c < NUM_OUT; c++)
            begin
                out_reg[c] <= lane_res[c];
            end
        end
    end

    assign result_chan.valid        = out_valid_reg;
    assign result_chan.filtered_ch0 = out_reg[0];
    assign result_chan.filtered_ch1 = out_reg[1];
    assign result_chan.filtered_ch2 = out_reg[2];
    assign result_chan.filtered_ch3 = out_reg[3];
    assign result_chan.filtered_ch4 = out_reg[4];
    assign result_chan.filtered_ch5 = out_reg[5];

`ifndef SYNTHESIS
    a_sample_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (is_sample && enable_reg) |=> (state_reg == ST_RUN))
        else $error("enabled sample did not start the tap walk");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the done state");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!s1_reg && !s2_reg))
        else $error("mac pipeline busy while idle");

    a_load_keeps_pointer: assert property (@(posedge clk) disable iff (!rst_n)
        is_load |=> ($stable(wp_reg) && $stable(full_reg)))
        else $error("tap load moved the ring pointer");

    a_disabled_keeps_pointer: assert property (@(posedge clk) disable iff (!rst_n)
        (is_sample && !enable_reg) |=> (state_reg == ST_DONE && $stable(wp_reg)))
        else $error("disabled sample touched the ring");
`endif

endmodule

`default_nettype wire

### test/multichannel_fir_ring_filter_tb.sv
// testbench for the multichannel fir ring filter: directed and random traffic checked against a predictor
module multichannel_fir_ring_filter_tb;
    import mfir_pkg::*;

    localparam int WINDOW      = WINDOW_DEF;
    localparam int SETTLE      = WINDOW + 10;
    localparam int STALL_LIMIT = 4000;

    localparam sample_t Q15_MAX    = 16'sh7FFF;
    localparam sample_t Q15_MIN    = 16'sh8000;
    localparam sample_t DERIV_STEP = -16'sd2;

    typedef sample_t [NUM_OUT-1:0] smp_set_t;
    typedef result_t [NUM_OUT-1:0] filt_set_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    mfir_sample_if sample_chan ();
    mfir_result_if result_chan ();

    multichannel_fir_ring_filter #(
        .WINDOW   (WINDOW),
        .CHANNELS (NUM_OUT)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .sample_chan (sample_chan),
        .result_chan (result_chan)
    );

    sample_t   ring [NUM_OUT][WINDOW];
    sample_t   tap_coef [WINDOW];
    int        wr_ptr;
    logic      filter_on;
    filt_set_t filt_expect_q [$];
    filt_set_t got_set;
    filt_set_t want_set;
    int        errors = 0;
    int        src_idle_pct;
    int        snk_idle_pct;
    int        quiet_cycles = 0;

    always #4 clk = ~clk;

    function automatic void model_item(input logic op, input logic [TAP_IDX_W-1:0] tap,
                                       input sample_t coef, input smp_set_t smp);
        filt_set_t out_set;
        longint    acc;
        int        pos;
        if (op == OP_LOAD)
        begin
            if (tap < WINDOW)
                tap_coef[tap] = coef;
            return;
        end
        out_set = '0;
        if (filter_on)
        begin
            for (int c = 0; c < NUM_OUT; c++)
                ring[c][wr_ptr] = smp[c];
            wr_ptr = (wr_ptr + 1) % WINDOW;
            for (int c = 0; c < NUM_OUT; c++)
            begin
                acc = 0;
                for (int j = 0; j < WINDOW; j++)
                begin
                    pos = (wr_ptr + WINDOW - 1 - j) % WINDOW;
                    acc += longint'(ring[c][pos]) * longint'(tap_coef[j]);
                end
                acc = acc >>> FRAC_W;
                if (acc > 64'sd2147483647)
                    acc = 64'sd2147483647;
                if (acc < -64'sd2147483648)
                    acc = -64'sd2147483648;
                out_set[c] = result_t'(acc);
            end
        end
        filt_expect_q = {filt_expect_q, out_set};
    endfunction

    function automatic sample_t rand_word();
        case ($urandom_range(7))
            0: return Q15_MIN;
            1: return Q15_MAX;
            2: return sample_t'(int'($urandom_range(16)) - 8);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic smp_set_t rand_set();
        smp_set_t s;
        for (int c = 0; c < NUM_OUT; c++)
            s[c] = rand_word();
        return s;
    endfunction

    // filtered transaction check
    always @(posedge clk)
    begin
        if (!rst_n)
            result_chan.ready <= 1'b0;
        else
        begin
            if (result_chan.valid && result_chan.ready)
            begin
                got_set = {result_chan.filtered_ch5, result_chan.filtered_ch4,
                           result_chan.filtered_ch3, result_chan.filtered_ch2,
                           result_chan.filtered_ch1, result_chan.filtered_ch0};
                if (filt_expect_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result transaction with nothing expected", $time);
                end
                else
                begin
                    want_set = filt_expect_q.pop_front();
                    for (int c = 0; c < NUM_OUT; c++)
                        if (got_set[c] !== want_set[c])
                        begin
                            errors++;
                            $display("%0t: filtered_ch%0d expected %0d actual %0d", $time, c,
                                     $signed(want_set[c]), $signed(got_set[c]));
                        end
                end
            end
            result_chan.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((sample_chan.valid && sample_chan.ready) || (result_chan.valid && result_chan.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("multichannel_fir_ring_filter_tb NOT OK");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [TAP_IDX_W-1:0] tap,
                             input sample_t coef, input smp_set_t smp);
        while ($urandom_range(99) < src_idle_pct)
        begin
            sample_chan.valid <= 1'b0;
            @(posedge clk);
        end
        sample_chan.valid      <= 1'b1;
        sample_chan.opcode     <= op;
        sample_chan.tap_index  <= tap;
        sample_chan.coef_value <= coef;
        sample_chan.sample_ch0 <= smp[0];
        sample_chan.sample_ch1 <= smp[1];
        sample_chan.sample_ch2 <= smp[2];
        sample_chan.sample_ch3 <= smp[3];
        sample_chan.sample_ch4 <= smp[4];
        sample_chan.sample_ch5 <= smp[5];
        @(posedge clk);
        while (!sample_chan.ready)
            @(posedge clk);
        model_item(op, tap, coef, smp);
    endtask

    task automatic send_load(input logic [TAP_IDX_W-1:0] tap, input sample_t coef);
        send_item(OP_LOAD, tap, coef, rand_set());
    endtask

    task automatic send_sample(input smp_set_t smp);
        send_item(OP_SAMPLE, TAP_IDX_W'($urandom), rand_word(), smp);
    endtask

    // wait for every expected result, then let a load or late sample settle
    task automatic drain();
        sample_chan.valid <= 1'b0;
        while (filt_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_enable(input logic value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        filter_on = value;
    endtask

    task automatic test_disabled_after_reset();
        send_sample({NUM_OUT{Q15_MAX}});
        send_load(0, Q15_MAX);
        send_load(1, DERIV_STEP);
        send_sample({NUM_OUT{Q15_MIN}});
    endtask

    task automatic test_extremes();
        send_load(TAP_IDX_W'(WINDOW - 1), Q15_MIN);
        send_sample({Q15_MAX, 16'sh0001, -16'sd1, 16'sh0000, Q15_MIN, Q15_MAX});
        send_sample({NUM_OUT{Q15_MIN}});
        send_sample({NUM_OUT{Q15_MAX}});
        send_load(0, Q15_MIN);
        send_load(2, 16'sh0000);
        send_sample({NUM_OUT{16'sh0000}});
        send_sample({Q15_MIN, Q15_MAX, Q15_MIN, Q15_MAX, Q15_MIN, Q15_MAX});
    endtask

    task automatic test_enable_holds_history();
        write_enable(1'b0);
        send_sample(rand_set());
        send_sample({NUM_OUT{Q15_MAX}});
        write_enable(1'b1);
        send_sample(rand_set());
        send_sample(rand_set());
    endtask

    task automatic test_full_scale();
        for (int j = 0; j < WINDOW; j++)
            send_load(TAP_IDX_W'(j), Q15_MIN);
        for (int k = 0; k <= WINDOW; k++)
            send_sample({NUM_OUT{Q15_MIN}});
        for (int k = 0; k < 4; k++)
            send_sample({NUM_OUT{Q15_MAX}});
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(4) == 0)
                send_load(TAP_IDX_W'($urandom), rand_word());
            else
                send_sample(rand_set());
        end
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        write_enable(1'b1);
        test_random(170);
        write_enable(1'b0);
        test_random(40);
        write_enable(1'b1);
        test_random(178);
    endtask

    initial
    begin
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_wdata              <= 1'b0;
        sample_chan.valid      <= 1'b0;
        sample_chan.opcode     <= OP_LOAD;
        sample_chan.tap_index  <= '0;
        sample_chan.coef_value <= '0;
        sample_chan.sample_ch0 <= '0;
        sample_chan.sample_ch1 <= '0;
        sample_chan.sample_ch2 <= '0;
        sample_chan.sample_ch3 <= '0;
        sample_chan.sample_ch4 <= '0;
        sample_chan.sample_ch5 <= '0;
        for (int c = 0; c < NUM_OUT; c++)
            for (int j = 0; j < WINDOW; j++)
                ring[c][j] = '0;
        for (int j = 0; j < WINDOW; j++)
            tap_coef[j] = '0;
        wr_ptr       = 0;
        filter_on    = 1'b0;
        src_idle_pct = 22;
        snk_idle_pct = 74;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_after_reset();
        write_enable(1'b1);
        test_extremes();
        test_enable_holds_history();
        test_full_scale();
        run_phase(22, 74);
        run_phase(74, 22);
        run_phase(0, 0);
        drain();

        if (errors == 0)
            $display("multichannel_fir_ring_filter_tb OK");
        else
            $display("multichannel_fir_ring_filter_tb NOT OK");
        $finish;
    end

endmodule

### multichannel_fir_ring_filter.f
hw/rtl/mfir_pkg.sv
hw/rtl/mfir_sample_if.sv
hw/rtl/mfir_result_if.sv
hw/rtl/mfir_ram.sv
hw/rtl/mfir_mac.sv
hw/rtl/multichannel_fir_ring_filter.sv
test/multichannel_fir_ring_filter_tb.sv
